@@ hdl/pkgf_pkg.sv @@
// Shared types and constants of the per-key generation fence.
package pkgf_pkg;

   localparam int KEY_W = 64;
   localparam int GEN_W = 64;
   localparam int CAP_W = 7;
   localparam logic [CAP_W-1:0] CAPACITY_RESET = 7'd64;

   typedef enum logic [2:0] {
      STATUS_NO_ROUND = 3'd0,
      STATUS_INSERTED = 3'd1,
      STATUS_RAISED   = 3'd2,
      STATUS_STALE    = 3'd3,
      STATUS_FULL     = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SEARCH,
      FSM_RESULT
   } fsm_type;

   typedef struct packed {
      logic active;
      logic resolved;
      logic stale;
      logic inserted;
   } link_type;

endpackage

@@ hdl/pkgf_cell.sv @@
// One table slot: key, high-water mark and valid bit, with the probe hand-off.
module pkgf_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  pkgf_pkg::link_type        up_link,
   input  logic                      room,
   input  logic [pkgf_pkg::KEY_W-1:0] key,
   input  logic [pkgf_pkg::GEN_W-1:0] gen,
   output pkgf_pkg::link_type        down_link
);

   logic [pkgf_pkg::KEY_W-1:0] key_ff, key_in;
   logic [pkgf_pkg::GEN_W-1:0] mark_ff, mark_in;
   logic                       valid_ff, valid_in;
   pkgf_pkg::link_type         link_ff, link_in;
   logic                       probe, hit, take, stale;

   always_comb begin
      probe    = up_link.active && !up_link.resolved;
      hit      = probe && valid_ff && (key_ff == key);
      take     = probe && !valid_ff && room;
      stale    = gen < mark_ff;
      link_in  = up_link;
      key_in   = key_ff;
      mark_in  = mark_ff;
      valid_in = valid_ff;
      if (hit) begin
         link_in.resolved = 1'b1;
         link_in.stale    = stale;
         if (!stale) begin
            mark_in = gen;
         end
      end
      if (take) begin
         link_in.resolved = 1'b1;
         link_in.inserted = 1'b1;
         key_in           = key;
         mark_in          = gen;
         valid_in         = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         link_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         link_ff  <= link_in;
      end
      key_ff  <= key_in;
      mark_ff <= mark_in;
   end

   assign down_link = link_ff;

endmodule

@@ hdl/per_key_generation_fence.sv @@
// Top level: request/response control, occupancy, capacity register and the cell row.
// An accepted word sends the probe down the row through each cell's link register in turn;
// the result is registered as the probe leaves the row. Generation zero skips the row.
// One word is in flight at a time: new words stall until the result has been taken.
// Reset clears all valid bits, occupancy and the probe at once; capacity returns to 64.
module per_key_generation_fence #(
   parameter int ENTRIES = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [pkgf_pkg::KEY_W-1:0]  req_chunk_id,
   input  logic [pkgf_pkg::GEN_W-1:0]  req_generation,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_admitted,
   output logic [2:0]                  rsp_status,
   input  logic                        csr_write_enable,
   input  logic [pkgf_pkg::CAP_W-1:0]  csr_write_data
);

   localparam int OCC_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (OCC_W > pkgf_pkg::CAP_W) ? OCC_W : pkgf_pkg::CAP_W;

   pkgf_pkg::fsm_type            state_ff, state_in;
   pkgf_pkg::status_type         status_ff, status_in;
   pkgf_pkg::link_type           head_ff, head_in;
   logic [pkgf_pkg::KEY_W-1:0]   key_ff, key_in;
   logic [pkgf_pkg::GEN_W-1:0]   gen_ff, gen_in;
   logic [OCC_W-1:0]             occ_ff, occ_in;
   logic [pkgf_pkg::CAP_W-1:0]   cap_ff, cap_in;
   logic                         room_ff, room_in;
   logic                         admitted_ff, admitted_in;
   logic                         accept;
   pkgf_pkg::link_type           links [0:ENTRIES];
   pkgf_pkg::link_type           tail;

   assign links[0] = head_ff;
   assign tail     = links[ENTRIES];

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      pkgf_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .up_link   (links[i]),
         .room      (room_ff),
         .key       (key_ff),
         .gen       (gen_ff),
         .down_link (links[i+1])
      );
   end

   always_comb begin
      accept      = req_valid && (state_ff == pkgf_pkg::FSM_IDLE);
      state_in    = state_ff;
      status_in   = status_ff;
      admitted_in = admitted_ff;
      head_in     = '0;
      key_in      = key_ff;
      gen_in      = gen_ff;
      occ_in      = occ_ff;
      room_in     = room_ff;
      cap_in      = csr_write_enable ? csr_write_data : cap_ff;
      unique case (state_ff)
         pkgf_pkg::FSM_IDLE: begin
            if (accept) begin
               key_in  = req_chunk_id;
               gen_in  = req_generation;
               room_in = (occ_ff < OCC_W'(ENTRIES)) && (CMP_W'(occ_ff) < CMP_W'(cap_ff));
               if (req_generation == '0) begin
                  status_in   = pkgf_pkg::STATUS_NO_ROUND;
                  admitted_in = 1'b1;
                  state_in    = pkgf_pkg::FSM_RESULT;
               end else begin
                  head_in.active = 1'b1;
                  state_in       = pkgf_pkg::FSM_SEARCH;
               end
            end
         end
         pkgf_pkg::FSM_SEARCH: begin
            if (tail.active) begin
               priority if (!tail.resolved) begin
                  status_in   = pkgf_pkg::STATUS_FULL;
                  admitted_in = 1'b0;
               end else if (tail.stale) begin
                  status_in   = pkgf_pkg::STATUS_STALE;
                  admitted_in = 1'b0;
               end else if (tail.inserted) begin
                  status_in   = pkgf_pkg::STATUS_INSERTED;
                  admitted_in = 1'b1;
                  occ_in      = occ_ff + 1'b1;
               end else begin
                  status_in   = pkgf_pkg::STATUS_RAISED;
                  admitted_in = 1'b1;
               end
               state_in = pkgf_pkg::FSM_RESULT;
            end
         end
         pkgf_pkg::FSM_RESULT: begin
            if (!rsp_stall) begin
               state_in = pkgf_pkg::FSM_IDLE;
            end
         end
         default: begin
            state_in = pkgf_pkg::FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pkgf_pkg::FSM_IDLE;
         head_ff  <= '0;
         occ_ff   <= '0;
         cap_ff   <= pkgf_pkg::CAPACITY_RESET;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         occ_ff   <= occ_in;
         cap_ff   <= cap_in;
      end
      status_ff   <= status_in;
      admitted_ff <= admitted_in;
      key_ff      <= key_in;
      gen_ff      <= gen_in;
      room_ff     <= room_in;
   end

   assign req_stall    = (state_ff != pkgf_pkg::FSM_IDLE);
   assign rsp_valid    = (state_ff == pkgf_pkg::FSM_RESULT);
   assign rsp_admitted = admitted_ff;
   assign rsp_status   = status_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(ENTRIES))
      else $error("occupancy beyond table size");

   a_occ_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (occ_ff == $past(occ_ff) || occ_ff == $past(occ_ff) + 1'b1))
      else $error("occupancy moved by more than one");

   a_tail_search: assert property (@(posedge clock) disable iff (reset)
      tail.active |-> state_ff == pkgf_pkg::FSM_SEARCH)
      else $error("probe left the row outside a search");

   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      (tail.active && tail.inserted) |-> room_ff)
      else $error("insertion without room");

   a_admit_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_admitted == (rsp_status == pkgf_pkg::STATUS_NO_ROUND ||
                                      rsp_status == pkgf_pkg::STATUS_INSERTED ||
                                      rsp_status == pkgf_pkg::STATUS_RAISED)))
      else $error("admission flag disagrees with status");

endmodule
